// ===== hdl/adfgvx_pair_decode_quadgram_score_macros.svh =====
// Assertion helpers, clocked on clk and held off during rst.
`ifndef ADFGVX_PAIR_DECODE_QUADGRAM_SCORE_MACROS_SVH
`define ADFGVX_PAIR_DECODE_QUADGRAM_SCORE_MACROS_SVH

// Consequent checked in the same cycle.
`define ADQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle.
`define ADQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/adfgvx_qs_pkg.sv =====
package adfgvx_qs_pkg;

  localparam int S_TDATA_W  = 48;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 60;

  localparam int ADDR_W    = 19;
  localparam int VAL_W     = 16;
  localparam int CODE_W    = 5;
  localparam int COORD_W   = 3;
  localparam int SUM_W     = 32;
  localparam int DIV_STEPS = 32;

  localparam int TABLE_DEPTH = 456976;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COORD_W-1:0] coord_t;

  localparam logic [CFG_IDX_W-1:0] REG_SQ01    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQ23    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQ45    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY = 2'd3;

  localparam logic REQ_TABLE  = 1'b0;
  localparam logic REQ_SYMBOL = 1'b1;

  localparam code_t NONLETTER   = 5'd26;
  localparam code_t LAST_LETTER = 5'd25;

  localparam coord_t COORD_MAX = 3'd5;
  localparam coord_t COORD_BAD = 3'd7;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_D = 8'h44;
  localparam logic [7:0] SYM_F = 8'h46;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_V = 8'h56;
  localparam logic [7:0] SYM_X = 8'h58;

  localparam logic [ADDR_W-1:0] WEIGHT_1 = 19'd17576;
  localparam logic [ADDR_W-1:0] WEIGHT_2 = 19'd676;
  localparam logic [ADDR_W-1:0] WEIGHT_3 = 19'd26;

  function automatic coord_t coord_of(input logic [7:0] b);
    coord_t c;
    case (b)
      SYM_A:   c = 3'd0;
      SYM_D:   c = 3'd1;
      SYM_F:   c = 3'd2;
      SYM_G:   c = 3'd3;
      SYM_V:   c = 3'd4;
      SYM_X:   c = 3'd5;
      default: c = COORD_BAD;
    endcase
    return c;
  endfunction

  // raw 5-bit square entry; row and column assumed valid
  function automatic code_t square_entry(input logic [CFG_DATA_W-1:0] sq01,
                                         input logic [CFG_DATA_W-1:0] sq23,
                                         input logic [CFG_DATA_W-1:0] sq45,
                                         input coord_t r, input coord_t c);
    logic [CFG_DATA_W-1:0] rowpair;
    logic [3:0] slot;
    case (r[2:1])
      2'd0:    rowpair = sq01;
      2'd1:    rowpair = sq23;
      default: rowpair = sq45;
    endcase
    slot = (r[0] ? 4'd6 : 4'd0) + {1'b0, c};
    return rowpair[slot*5 +: CODE_W];
  endfunction

endpackage

// ===== hdl/adfgvx_pair_decode_quadgram_score.sv =====
// A table write or an unpaired symbol is taken in the idle state. A symbol pair is accepted
// (table read issued), then accumulated; its result goes to the output register once the output is free.
// End of text adds a setup state, the bit-serial mean divider (skipped when no window was
// scored) and a state that loads the score result.
// rst is synchronous, active high: returns config registers to their reset values and
// clears per-text state; the quadgram memory is not cleared.
`include "adfgvx_pair_decode_quadgram_score_macros.svh"

module adfgvx_pair_decode_quadgram_score #(
  parameter int MAX_PLAIN = 2048,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // table_index, table_value, symbol_byte, zero pad
  input  logic [adfgvx_qs_pkg::S_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic [adfgvx_qs_pkg::S_TUSER_W-1:0]  s_tuser,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // plain_code, fitness, zero pad
  output logic [adfgvx_qs_pkg::M_TDATA_W-1:0]  m_tdata,
  // plain_valid, score_valid
  output logic [adfgvx_qs_pkg::M_TUSER_W-1:0]  m_tuser,
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [adfgvx_qs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adfgvx_qs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import adfgvx_qs_pkg::*;

  localparam int WIN_MAX = MAX_PLAIN - 3;
  localparam int WT_W    = $clog2(MAX_PLAIN - 2);

  localparam longint PEN_RAW  = -(longint'(7) <<< FRAC_BITS);
  localparam longint NONE_RAW = -(longint'(99) <<< FRAC_BITS);
  localparam logic [VAL_W-1:0] PEN_RESET  = VAL_W'((PEN_RAW < -32768) ? -32768 : PEN_RAW);
  localparam logic [VAL_W-1:0] FIT_NONE   = VAL_W'((NONE_RAW < -32768) ? -32768 : NONE_RAW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;

  logic [CFG_DATA_W-1:0] sq01, sq23, sq45;
  logic [VAL_W-1:0]      penalty;

  logic [3*CODE_W-1:0]   recent;
  logic [1:0]            hfill;
  coord_t                held;
  logic                  sheld;
  logic signed [SUM_W-1:0] ssum;
  logic [WT_W-1:0]       wtot;

  code_t pc_reg;
  logic  pv_reg, win_reg, ok_reg, last_reg, none_reg;

  logic [SUM_W-1:0] dvd, quo;
  logic [WT_W-1:0]  rem;
  logic             neg;
  logic [4:0]       cnt;

  logic [VAL_W-1:0]  quad_table [TABLE_DEPTH];
  logic [VAL_W-1:0]  tbl_rdata;
  logic              tbl_we;
  logic [ADDR_W-1:0] raddr;

  logic        acc, is_sym, out_free, ok, win, emit;
  coord_t      cd;
  code_t       entry, pc, la, lb, lc;
  logic [WT_W:0]   rshift, diff;
  logic signed [SUM_W:0] qsig;
  logic [VAL_W-1:0] fit_sat;

  assign s_tready = !rst && (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign is_sym   = (s_tuser[0] == REQ_SYMBOL);
  assign out_free = !m_tvalid || m_tready;
  assign m_tlast  = m_tuser[1];
  assign emit     = out_free && ((state == S_EMIT) || (state == S_FIN) ||
                                 ((state == S_ACC) && !last_reg));

  always_comb begin
    cd    = coord_of(s_tdata[42:35]);
    entry = square_entry(sq01, sq23, sq45, held, cd);
    if (held > COORD_MAX || cd > COORD_MAX || entry > LAST_LETTER) begin
      pc = NONLETTER;
    end else begin
      pc = entry;
    end
    la = recent[14:10];
    lb = recent[9:5];
    lc = recent[4:0];
    ok = (la <= LAST_LETTER) && (lb <= LAST_LETTER) && (lc <= LAST_LETTER) &&
         (pc <= LAST_LETTER);
    win = (hfill == 2'd3) && (wtot < WT_W'(WIN_MAX));
    raddr = ADDR_W'(la) * WEIGHT_1 + ADDR_W'(lb) * WEIGHT_2 + ADDR_W'(lc) * WEIGHT_3 +
            ADDR_W'(pc);
    tbl_we = acc && !is_sym && (s_tdata[18:0] < ADDR_W'(TABLE_DEPTH));
  end

  always_comb begin
    rshift = {rem, dvd[SUM_W-1]};
    diff   = rshift - {1'b0, wtot};
    qsig   = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (qsig > 33'sd32767) begin
      fit_sat = 16'h7fff;
    end else if (qsig < -33'sd32768) begin
      fit_sat = 16'h8000;
    end else begin
      fit_sat = qsig[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      quad_table[s_tdata[18:0]] <= s_tdata[34:19];
    end
    tbl_rdata <= quad_table[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sq01     <= '0;
      sq23     <= '0;
      sq45     <= '0;
      penalty  <= PEN_RESET;
      recent   <= '0;
      hfill    <= '0;
      held     <= '0;
      sheld    <= 1'b0;
      ssum     <= '0;
      wtot     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SQ01:    sq01 <= cfg_data;
          REG_SQ23:    sq23 <= cfg_data;
          REG_SQ45:    sq45 <= cfg_data;
          REG_PENALTY: penalty <= cfg_data[VAL_W-1:0];
          default:     ;
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc && is_sym) begin
            last_reg <= s_tlast;
            if (!sheld) begin
              held   <= cd;
              sheld  <= 1'b1;
              pv_reg <= 1'b0;
              pc_reg <= '0;
              if (s_tlast) begin
                state <= S_START;
              end
            end else begin
              held    <= '0;
              sheld   <= 1'b0;
              pv_reg  <= 1'b1;
              pc_reg  <= pc;
              win_reg <= win;
              ok_reg  <= ok;
              recent  <= {recent[2*CODE_W-1:0], pc};
              if (hfill != 2'd3) begin
                hfill <= hfill + 2'd1;
              end
              state <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (win_reg) begin
            ssum <= ssum + SUM_W'($signed(ok_reg ? tbl_rdata : penalty));
            wtot <= wtot + WT_W'(1);
          end
          if (last_reg) begin
            state <= S_START;
          end else if (out_free) begin
            m_tuser  <= {1'b0, pv_reg};
            m_tdata  <= {3'b000, {VAL_W{1'b0}}, pc_reg};
            state    <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tuser  <= {1'b0, pv_reg};
            m_tdata  <= {3'b000, {VAL_W{1'b0}}, pc_reg};
            state    <= S_IDLE;
          end
        end
        S_START: begin
          none_reg <= (wtot == '0);
          neg      <= ssum[SUM_W-1];
          dvd      <= ssum[SUM_W-1] ? SUM_W'(-ssum) : SUM_W'(ssum);
          rem      <= '0;
          quo      <= '0;
          cnt      <= '0;
          state    <= (wtot == '0) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          dvd <= {dvd[SUM_W-2:0], 1'b0};
          if (!diff[WT_W]) begin
            rem <= diff[WT_W-1:0];
            quo <= {quo[SUM_W-2:0], 1'b1};
          end else begin
            rem <= rshift[WT_W-1:0];
            quo <= {quo[SUM_W-2:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tuser  <= {1'b1, pv_reg};
            m_tdata  <= {3'b000, (none_reg ? FIT_NONE : fit_sat), pc_reg};
            recent   <= '0;
            hfill    <= '0;
            held     <= '0;
            sheld    <= 1'b0;
            ssum     <= '0;
            wtot     <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ADQS_ASSERT_NEXT(a_pair_to_acc, acc && is_sym && sheld, state == S_ACC,
                    "completed pair did not go to accumulate")
  `ADQS_ASSERT_NOW(a_div_nonzero, state == S_DIV, wtot != '0,
                   "divider running with zero window count")
  `ADQS_ASSERT_NEXT(a_text_cleared, state == S_FIN && out_free,
                    !sheld && hfill == 2'd0 && wtot == '0,
                    "per-text state not cleared after score")
  `ADQS_ASSERT_NOW(a_window_cap, 1'b1, wtot <= WT_W'(WIN_MAX),
                   "window count above limit")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import adfgvx_qs_pkg::*;

  localparam int MAX_WINDOWS   = 2048 - 3;
  localparam int FRAC          = 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 48;
  localparam int RANDOM_ITEMS  = 300;
  localparam int LONG_SYMBOLS  = 120;

  typedef struct packed {
    logic        kind;
    logic [18:0] index;
    logic [15:0] value;
    logic [7:0]  sym;
    logic        eot;
  } request_t;

  typedef struct {
    bit          plain_v;
    code_t       code;
    bit          score_v;
    logic [15:0] fit;
    bit          last;
  } outcome_t;

  class pair_score_model;
    logic [CFG_DATA_W-1:0] square [3];
    logic signed [15:0]    penalty;
    logic signed [15:0]    quad [int];
    logic [14:0]           recent;
    int                    fill;
    coord_t                held;
    bit                    held_v;
    longint                sum;
    int                    windows;
    bit                    keeps_outcomes;
    outcome_t              pending_outputs [$];
    int                    errors;

    function new(bit keep);
      keeps_outcomes = keep;
      errors = 0;
      square[0] = '0;
      square[1] = '0;
      square[2] = '0;
      penalty = sat_q(-(longint'(7) << FRAC));
      clear_text();
    endfunction

    function logic signed [15:0] sat_q(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function void clear_text();
      recent = '0;
      fill = 0;
      held = '0;
      held_v = 0;
      sum = 0;
      windows = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SQ01:    square[0] = data;
        REG_SQ23:    square[1] = data;
        REG_SQ45:    square[2] = data;
        REG_PENALTY: penalty = data[15:0];
        default: ;
      endcase
    endfunction

    function coord_t coord_for(logic [7:0] b);
      case (b)
        SYM_A:   return 3'd0;
        SYM_D:   return 3'd1;
        SYM_F:   return 3'd2;
        SYM_G:   return 3'd3;
        SYM_V:   return 3'd4;
        SYM_X:   return 3'd5;
        default: return COORD_BAD;
      endcase
    endfunction

    function code_t pair_code(coord_t r, coord_t c);
      logic [CFG_DATA_W-1:0] rows;
      code_t                 e;
      int                    slot;
      if (r > COORD_MAX || c > COORD_MAX) return NONLETTER;
      rows = square[int'(r) / 2];
      slot = (int'(r) % 2) * 6 + int'(c);
      e = rows[slot*5 +: CODE_W];
      return (e > LAST_LETTER) ? NONLETTER : e;
    endfunction

    function int quad_index(code_t a, code_t b, code_t c, code_t d);
      return ((int'(a) * 26 + int'(b)) * 26 + int'(c)) * 26 + int'(d);
    endfunction

    // index that this request would read from an unwritten table entry, else -1
    function int missing_quad(request_t r);
      code_t pc;
      code_t a;
      code_t b;
      code_t c;
      int    idx;
      if (r.kind != REQ_SYMBOL || !held_v) return -1;
      if (fill != 3 || windows >= MAX_WINDOWS) return -1;
      pc = pair_code(held, coord_for(r.sym));
      a = recent[14:10];
      b = recent[9:5];
      c = recent[4:0];
      if (a > LAST_LETTER || b > LAST_LETTER || c > LAST_LETTER || pc > LAST_LETTER)
        return -1;
      idx = quad_index(a, b, c, pc);
      return quad.exists(idx) ? -1 : idx;
    endfunction

    function void push_code(code_t pc);
      code_t a;
      code_t b;
      code_t c;
      int    idx;
      if (fill == 3) begin
        a = recent[14:10];
        b = recent[9:5];
        c = recent[4:0];
        if (windows < MAX_WINDOWS) begin
          if (a > LAST_LETTER || b > LAST_LETTER || c > LAST_LETTER || pc > LAST_LETTER) begin
            sum += penalty;
          end else begin
            idx = quad_index(a, b, c, pc);
            if (quad.exists(idx)) sum += quad[idx];
          end
          windows++;
        end
      end else begin
        fill++;
      end
      recent = {recent[9:0], pc};
    endfunction

    function void note_request(request_t r);
      coord_t   cd;
      code_t    pc;
      bit       paired;
      outcome_t o;
      if (r.kind == REQ_TABLE) begin
        if (r.index < TABLE_DEPTH) quad[int'(r.index)] = r.value;
        return;
      end
      cd = coord_for(r.sym);
      paired = 0;
      pc = '0;
      if (!held_v) begin
        held = cd;
        held_v = 1;
      end else begin
        pc = pair_code(held, cd);
        held = '0;
        held_v = 0;
        push_code(pc);
        paired = 1;
      end
      if (!r.eot && !paired) return;
      o.plain_v = paired;
      o.code = pc;
      o.score_v = r.eot;
      o.last = r.eot;
      o.fit = '0;
      if (r.eot) begin
        if (windows == 0) o.fit = sat_q(-(longint'(99) << FRAC));
        else o.fit = sat_q(sum / longint'(windows));
        clear_text();
      end
      if (keeps_outcomes) pending_outputs.push_back(o);
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_output(outcome_t got);
      outcome_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual code %0d fitness 0x%0h",
                 $time, got.code, got.fit);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      compare("plain_valid", want.plain_v, got.plain_v);
      compare("plain_code", want.code, got.code);
      compare("score_valid", want.score_v, got.score_v);
      compare("fitness", want.fit, got.fit);
      compare("is_last", want.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pair_score_model score_model = new(1'b1);
  pair_score_model plan_model = new(1'b0);
  request_t        stim_q [$];
  int              send_idle = 36;
  int              recv_idle = 80;
  bit              hold_pending = 0;
  int              hold_left = 0;
  int              quiet = 0;

  adfgvx_pair_decode_quadgram_score u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // table_index, table_value, symbol_byte, zero pad
    .s_tuser   (s_tuser),   // req_type
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // plain_code, fitness, zero pad
    .m_tuser   (m_tuser),   // plain_valid, score_valid
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      score_model.note_request('{kind: s_tuser[0], index: s_tdata[18:0],
                                 value: s_tdata[34:19], sym: s_tdata[42:35], eot: s_tlast});
  end

  always @(posedge clk) begin
    outcome_t o;
    if (!rst && m_tvalid && m_tready) begin
      o.plain_v = m_tuser[0];
      o.score_v = m_tuser[1];
      o.code = m_tdata[4:0];
      o.fit = m_tdata[20:5];
      o.last = m_tlast;
      score_model.check_output(o);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no request or result moved for %0d cycles", $time, quiet);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic request_t table_req(logic [18:0] idx, logic [15:0] value, logic eot);
    request_t r;
    r.kind = REQ_TABLE;
    r.index = idx;
    r.value = value;
    r.sym = 8'($urandom);
    r.eot = eot;
    return r;
  endfunction

  function automatic request_t symbol_req(logic [7:0] b, logic eot);
    request_t r;
    r.kind = REQ_SYMBOL;
    r.index = 19'($urandom);
    r.value = 16'($urandom);
    r.sym = b;
    r.eot = eot;
    return r;
  endfunction

  // quadgrams the text will need are loaded just ahead of it
  function automatic void queue_request(request_t r);
    int       idx;
    request_t load;
    idx = plan_model.missing_quad(r);
    if (idx >= 0) begin
      load = table_req(idx[18:0], 16'($urandom), 1'b0);
      stim_q.push_back(load);
      plan_model.note_request(load);
    end
    stim_q.push_back(r);
    plan_model.note_request(r);
  endfunction

  function automatic void queue_word(string w);
    for (int i = 0; i < w.len(); i++)
      queue_request(symbol_req(w[i], i == w.len() - 1));
  endfunction

  function automatic logic [7:0] pick_symbol(int bad_pct);
    if ($urandom_range(0, 99) < bad_pct) return 8'($urandom);
    case ($urandom_range(0, 5))
      0:       return SYM_A;
      1:       return SYM_D;
      2:       return SYM_F;
      3:       return SYM_G;
      4:       return SYM_V;
      default: return SYM_X;
    endcase
  endfunction

  // narrow: letters only a or z, non-letters all ones
  function automatic logic [CFG_DATA_W-1:0] make_square(int letter_pct, bit narrow);
    logic [CFG_DATA_W-1:0] sq;
    sq = '0;
    for (int j = 0; j < 12; j++) begin
      if ($urandom_range(0, 99) < letter_pct)
        sq[j*5 +: 5] = narrow ? ($urandom_range(0, 1) ? LAST_LETTER : 5'd0)
                              : 5'($urandom_range(0, 25));
      else
        sq[j*5 +: 5] = narrow ? 5'd31 : 5'($urandom_range(26, 31));
    end
    return sq;
  endfunction

  function automatic void build_random(int n);
    int made;
    int len;
    int roll;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        queue_request(table_req(19'($urandom), 16'($urandom), 1'($urandom)));
        made++;
      end else if (roll < 12) begin
        queue_request(symbol_req(8'($urandom), $urandom_range(0, 3) == 0));
        made++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 24);
        for (int k = 0; k < len; k++)
          queue_request(symbol_req(pick_symbol(5), k == len - 1));
        made += len;
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    score_model.set_reg(idx, data);
    plan_model.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_settings(logic [CFG_DATA_W-1:0] sq01, logic [CFG_DATA_W-1:0] sq23,
                               logic [CFG_DATA_W-1:0] sq45, logic [15:0] pen);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_SQ01, sq01);
    write_reg(REG_SQ23, sq23);
    write_reg(REG_SQ45, sq45);
    write_reg(REG_PENALTY, {junk[43:0], pen});
    cfg_we <= 1'b0;
  endtask

  task automatic run_and_drain();
    request_t r;
    while (stim_q.size() > 0) begin
      if ($urandom_range(0, 99) < send_idle) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end else begin
        r = stim_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, r.sym, r.value, r.index};
        s_tuser <= r.kind;
        s_tlast <= r.eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (score_model.pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every valid pair decodes to 'a'
    queue_request(table_req(19'd0, 16'h8000, 1'b1));
    queue_request(table_req(19'd456975, 16'h7FFF, 1'b0));
    queue_request(table_req(19'd456976, 16'h1234, 1'b0));
    queue_request(table_req(19'h7FFFF, 16'hFFFF, 1'b1));
    queue_word("X");
    queue_word("AD");
    queue_word("ADFGVXXVGFDA");
    queue_request(symbol_req(8'h00, 1'b0));
    queue_request(symbol_req(SYM_A, 1'b0));
    queue_request(symbol_req(8'hFF, 1'b0));
    queue_request(symbol_req(SYM_X, 1'b0));
    queue_request(symbol_req(8'h61, 1'b0));
    queue_request(symbol_req(SYM_D, 1'b0));
    queue_word("AAAA");
    run_and_drain();

    load_settings(make_square(75, 1), make_square(75, 1), make_square(75, 1), 16'h8000);
    queue_word("ADFGVXAXDVFG");
    queue_word("XXXGGGVVA");
    run_and_drain();

    send_idle = 36;
    recv_idle = 80;
    load_settings(make_square(85, 0), make_square(85, 0), make_square(85, 0), 16'h7FFF);
    build_random(RANDOM_ITEMS);
    run_and_drain();

    send_idle = 80;
    recv_idle = 36;
    load_settings(make_square(85, 0), make_square(85, 0), make_square(70, 0), 16'($urandom));
    build_random(RANDOM_ITEMS);
    run_and_drain();

    send_idle = 0;
    recv_idle = 0;
    load_settings(make_square(95, 0), make_square(85, 0), make_square(85, 0), 16'h0000);
    build_random(RANDOM_ITEMS);
    hold_pending = 1;
    run_and_drain();

    // one long text, then a short one to see the state cleared
    load_settings(make_square(90, 1), make_square(90, 1), make_square(90, 1), 16'($urandom));
    for (int k = 0; k < LONG_SYMBOLS; k++)
      queue_request(symbol_req(pick_symbol(0), k == LONG_SYMBOLS - 1));
    queue_word("ADFGVX");
    run_and_drain();

    if (score_model.errors == 0 && score_model.pending_outputs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
